>>> design/sdaf_pkg.sv
// Package for the signed decimal ASCII formatter.
// Holds the controller state type, the digit cell operation type and constants.
// No dependencies.
`default_nettype none

package sdaf_pkg;

   localparam int NUM_DIGITS  = 10;
   localparam int VALUE_W     = 32;
   localparam int DEC_W       = 4;
   localparam int CHAR_W      = 8;
   localparam int BCD_W       = 4;
   localparam int POS_W       = 4;
   localparam int CONV_CNT_W  = 5;

   localparam logic [CONV_CNT_W-1:0] CONV_LAST = CONV_CNT_W'(VALUE_W - 1);
   localparam logic [POS_W-1:0]      POS_LAST  = POS_W'(NUM_DIGITS - 1);
   localparam logic [DEC_W-1:0]      DEC_MAX   = DEC_W'(NUM_DIGITS - 1);

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_DABBLE,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_CONV,
      ST_SIGN,
      ST_DIGIT,
      ST_POINT
   } state_type;

endpackage

`default_nettype wire

>>> design/sdaf_if.sv
// Channel interfaces of the signed decimal ASCII formatter.
// Depends on sdaf_pkg for the field widths.
`default_nettype none

interface sdaf_req_if import sdaf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic [DEC_W-1:0]          frac_digits;

   modport source (output valid, value, frac_digits, input ready);
   modport sink (input valid, value, frac_digits, output ready);
endinterface

interface sdaf_rsp_if import sdaf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              last;

   modport source (output valid, char_out, last, input ready);
   modport sink (input valid, char_out, last, output ready);
endinterface

`default_nettype wire

>>> design/sdaf_bcd_cell.sv
// One decimal digit cell of the conversion chain.
// Shifts in binary bits with add-3 correction, passes whole digits upward, clears or holds.
// Depends on sdaf_pkg.
`default_nettype none

module sdaf_bcd_cell
   import sdaf_pkg::*;
(
   input  wire logic             clock,
   input  wire cell_ctl_type     ctl,
   input  wire logic             carry_in,
   input  wire logic [BCD_W-1:0] nbr_digit,
   output      logic             carry_out,
   output      logic [BCD_W-1:0] digit_out
);

   logic [BCD_W-1:0] digit_ff;
   logic [BCD_W-1:0] digit_in;
   logic [BCD_W-1:0] adj;

   always_comb begin
      adj = (digit_ff >= BCD_W'(5)) ? (digit_ff + BCD_W'(3)) : digit_ff;
      digit_in = digit_ff;
      case (ctl.op)
         CELL_CLEAR:  digit_in = '0;
         CELL_DABBLE: digit_in = {adj[BCD_W-2:0], carry_in};
         CELL_SHIFT:  digit_in = nbr_digit;
         default:     digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_out = adj[BCD_W-1];
   assign digit_out = digit_ff;

endmodule

`default_nettype wire

>>> design/signed_decimal_ascii_formatter_core.sv
// Signed decimal ASCII formatter, top level.
// A request transaction carries a signed value and a count of fractional digits. The block
// answers with one response transaction per ASCII character: an optional '-', the decimal
// digits without leading zeros, and a '.' before the fractional digits when the count is 1
// to 9. The final character of a number has last set. A zero value gives a single '0'.
// The block works on one number at a time; req.ready is high only while it is idle.
// After acceptance, the binary value runs through a chain of ten digit cells with shift and
// add-3 correction. The digits then leave the top cell one per cycle; a dropped leading
// zero never waits, but a character waits while the output register is full and rsp.ready
// is low, and the sign and point characters hold the chain while they go out. The next
// request can be accepted once the last character is in the output register, even before
// the receiver takes it. Characters sit in an output register; when the receiver stalls,
// the chain holds and nothing is lost. Reset is synchronous and active high: it returns
// the controller to idle and empties the output register. The digit cells need no reset.
// Depends on sdaf_pkg, sdaf_if and sdaf_bcd_cell.
`default_nettype none

module signed_decimal_ascii_formatter_core
   import sdaf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sdaf_req_if.sink  req,
   sdaf_rsp_if.source rsp
);

   state_type            state_ff, state_in;
   logic [CONV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 supp_ff, supp_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [DEC_W-1:0]     dec_ff, dec_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 last_ff, last_in;

   cell_ctl_type         ctl;
   logic                 slot;
   logic                 emit;
   logic [CHAR_W-1:0]    emit_char;
   logic                 emit_last;
   logic                 skip;
   logic                 point_here;
   logic [BCD_W-1:0]     top_digit;

   logic [NUM_DIGITS:0]  carry;
   logic [BCD_W-1:0]     digit [NUM_DIGITS];

   assign carry[0] = mag_ff[VALUE_W-1];

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      sdaf_bcd_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .carry_in  (carry[i]),
         .nbr_digit ((i == 0) ? BCD_W'(0) : digit[(i == 0) ? 0 : i - 1]),
         .carry_out (carry[i+1]),
         .digit_out (digit[i])
      );
   end

   assign top_digit  = digit[NUM_DIGITS-1];
   assign slot       = !rsp_valid_ff || rsp.ready;
   assign point_here = (dec_ff >= DEC_W'(1)) && (dec_ff <= DEC_MAX) &&
                       (pos_ff == (POS_LAST - POS_W'(dec_ff)));
   assign skip       = supp_ff && (top_digit == '0);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      supp_in   = supp_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      dec_in    = dec_ff;
      ctl.op    = CELL_HOLD;
      emit      = 1'b0;
      emit_char = CH_ZERO;
      emit_last = 1'b0;
      req.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               ctl.op = CELL_CLEAR;
               neg_in = req.value[VALUE_W-1];
               mag_in = req.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(req.value))
                                             : VALUE_W'(req.value);
               dec_in = req.frac_digits;
               cnt_in = '0;
               state_in = (req.value == '0) ? ST_ZERO : ST_CONV;
            end
         end
         ST_ZERO: begin
            if (slot) begin
               emit      = 1'b1;
               emit_char = CH_ZERO;
               emit_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_CONV: begin
            ctl.op = CELL_DABBLE;
            mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + CONV_CNT_W'(1);
            if (cnt_ff == CONV_LAST) begin
               pos_in   = '0;
               supp_in  = 1'b1;
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (slot) begin
               emit      = 1'b1;
               emit_char = CH_MINUS;
               state_in  = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (skip || slot) begin
               ctl.op = CELL_SHIFT;
               pos_in = pos_ff + POS_W'(1);
               if (!skip) begin
                  emit      = 1'b1;
                  emit_char = CH_ZERO + CHAR_W'(top_digit);
                  supp_in   = 1'b0;
               end
               if (pos_ff == POS_LAST) begin
                  emit_last = 1'b1;
                  state_in  = ST_IDLE;
               end else if (point_here) begin
                  state_in = ST_POINT;
               end
            end
         end
         ST_POINT: begin
            if (slot) begin
               emit      = 1'b1;
               emit_char = CH_POINT;
               supp_in   = 1'b0;
               state_in  = ST_DIGIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         char_in      = emit_char;
         last_in      = emit_last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         supp_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         supp_ff      <= supp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      dec_ff  <= dec_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.char_out = char_ff;
   assign rsp.last     = last_ff;

endmodule

`default_nettype wire
